### hdl/pst_pkg.sv
// Package: constants and types for the packet source tally block.
package pst_pkg;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned SlotW = $clog2(TableDepth);
  localparam int unsigned FillW = SlotW + 1;
  localparam int unsigned CountW = 32;
  localparam int unsigned KeyW = 32;

  localparam logic [15:0] EthIpv4 = 16'h0800;
  localparam logic [15:0] EthArp = 16'h0806;
  localparam logic [15:0] EthUncounted = 16'd105;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  typedef enum logic [2:0] {
    ClsTcp = 3'd0,
    ClsUdp = 3'd1,
    ClsIpv4 = 3'd2,
    ClsArp = 3'd3,
    ClsOther = 3'd4,
    ClsUncounted = 3'd5
  } pkt_class_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StUpdate,
    StDone
  } search_state_e;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [CountW-1:0] total;
    logic full;
  } search_res_t;

  function automatic logic [CountW-1:0] sat_inc(logic [CountW-1:0] v);
    return (&v) ? v : v + CountW'(1);
  endfunction
endpackage

### hdl/pst_search.sv
// Key table with linear search, find-or-insert and saturating per-key count.
module pst_search (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [pst_pkg::KeyW-1:0] key_i,
  output logic                     done_o,
  output pst_pkg::search_res_t     res_o
);
  logic [pst_pkg::KeyW-1:0] keys_mem [pst_pkg::TableDepth];
  logic [pst_pkg::CountW-1:0] cnt_mem [pst_pkg::TableDepth];

  pst_pkg::search_state_e state_q, state_d;
  logic [pst_pkg::FillW-1:0] fill_q, fill_d;
  logic [pst_pkg::FillW-1:0] idx_q, idx_d;
  logic [pst_pkg::KeyW-1:0] key_q;
  logic [pst_pkg::KeyW-1:0] rd_key_q;
  logic [pst_pkg::CountW-1:0] rd_cnt_q;
  logic rd_vld_q;
  logic [pst_pkg::SlotW-1:0] rd_slot_q;
  pst_pkg::search_res_t res_q, res_d;
  logic wr_en;
  logic [pst_pkg::SlotW-1:0] wr_addr;
  logic [pst_pkg::KeyW-1:0] wr_key;
  logic [pst_pkg::CountW-1:0] wr_cnt;
  logic hit;
  logic rd_en;

  assign hit = rd_vld_q && (rd_key_q == key_q);
  assign rd_en = (state_q == pst_pkg::StScan) && (idx_q < fill_q) && !hit;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      keys_mem[wr_addr] <= wr_key;
      cnt_mem[wr_addr] <= wr_cnt;
    end
    rd_key_q <= keys_mem[idx_q[pst_pkg::SlotW-1:0]];
    rd_cnt_q <= cnt_mem[idx_q[pst_pkg::SlotW-1:0]];
    rd_slot_q <= idx_q[pst_pkg::SlotW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pst_pkg::StIdle;
      fill_q <= '0;
      idx_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      idx_q <= idx_d;
      rd_vld_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) key_q <= key_i;
    res_q <= res_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pst_pkg::StIdle: if (start_i) state_d = pst_pkg::StScan;
      pst_pkg::StScan: if (hit || (!rd_vld_q && !rd_en)) state_d = pst_pkg::StDone;
      pst_pkg::StDone: state_d = pst_pkg::StIdle;
      default: state_d = pst_pkg::StIdle;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    fill_d = fill_q;
    res_d = res_q;
    wr_en = 1'b0;
    wr_addr = rd_slot_q;
    wr_key = key_q;
    wr_cnt = pst_pkg::sat_inc(rd_cnt_q);
    case (state_q)
      pst_pkg::StIdle: idx_d = '0;
      pst_pkg::StScan: begin
        if (rd_en) idx_d = idx_q + pst_pkg::FillW'(1);
        if (hit) begin
          wr_en = 1'b1;
          res_d.slot = rd_slot_q;
          res_d.total = wr_cnt;
          res_d.full = 1'b0;
        end else if (!rd_vld_q && !rd_en) begin
          if (fill_q < pst_pkg::FillW'(pst_pkg::TableDepth)) begin
            wr_en = 1'b1;
            wr_addr = fill_q[pst_pkg::SlotW-1:0];
            wr_cnt = pst_pkg::CountW'(1);
            fill_d = fill_q + pst_pkg::FillW'(1);
            res_d.slot = fill_q[pst_pkg::SlotW-1:0];
            res_d.total = pst_pkg::CountW'(1);
            res_d.full = 1'b0;
          end else begin
            res_d = '0;
            res_d.full = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign done_o = (state_q == pst_pkg::StDone);
  assign res_o = res_q;
endmodule

### hdl/packet_source_tally_top.sv
// Top level: packet classifier, saturating class counters and two source tables.
// One packet at a time. A packet that is IPv4 scans the address table and, for
// TCP or UDP, the port table in parallel, one stored key per cycle through a
// registered memory read; each table holds 256 entries. Non-IPv4 packets skip
// the tables. The result sits in an output register; the next packet is taken
// once it is delivered.
module packet_source_tally_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] eth_type_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [31:0] source_address_i,
  input  logic [15:0] source_port_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  packet_class_o,
  output logic [7:0]  address_slot_o,
  output logic [31:0] address_total_o,
  output logic [7:0]  port_slot_o,
  output logic [31:0] port_total_o,
  output logic        address_table_full_o,
  output logic        port_table_full_o,
  output logic [31:0] tcp_packets_o,
  output logic [31:0] udp_packets_o,
  output logic [31:0] arp_packets_o,
  output logic [31:0] other_packets_o
);
  logic busy_q, wait_a_q, wait_p_q, out_vld_q;
  logic [2:0] cls_q;
  logic [31:0] tcp_q, udp_q, arp_q, oth_q;
  logic accept, is_ip, is_l4;
  logic a_done, p_done;
  pst_pkg::search_res_t a_res, p_res;
  logic [2:0] cls;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = !busy_q && !out_vld_q;
  assign is_ip = eth_type_i == pst_pkg::EthIpv4;
  assign is_l4 = is_ip && (ip_protocol_i == pst_pkg::ProtoTcp ||
                           ip_protocol_i == pst_pkg::ProtoUdp);

  always_comb begin
    if (is_ip) begin
      if (ip_protocol_i == pst_pkg::ProtoTcp) cls = pst_pkg::ClsTcp;
      else if (ip_protocol_i == pst_pkg::ProtoUdp) cls = pst_pkg::ClsUdp;
      else cls = pst_pkg::ClsIpv4;
    end else if (eth_type_i == pst_pkg::EthArp) cls = pst_pkg::ClsArp;
    else if (eth_type_i == pst_pkg::EthUncounted) cls = pst_pkg::ClsUncounted;
    else cls = pst_pkg::ClsOther;
  end

  pst_search u_addr (
    .clk_i, .rst_ni, .start_i(accept && is_ip), .key_i(source_address_i),
    .done_o(a_done), .res_o(a_res)
  );
  pst_search u_port (
    .clk_i, .rst_ni, .start_i(accept && is_l4), .key_i({16'd0, source_port_i}),
    .done_o(p_done), .res_o(p_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      wait_a_q <= 1'b0;
      wait_p_q <= 1'b0;
      out_vld_q <= 1'b0;
      tcp_q <= '0;
      udp_q <= '0;
      arp_q <= '0;
      oth_q <= '0;
      cls_q <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        wait_a_q <= is_ip;
        wait_p_q <= is_l4;
        cls_q <= cls;
        case (cls)
          pst_pkg::ClsTcp: tcp_q <= pst_pkg::sat_inc(tcp_q);
          pst_pkg::ClsUdp: udp_q <= pst_pkg::sat_inc(udp_q);
          pst_pkg::ClsArp: arp_q <= pst_pkg::sat_inc(arp_q);
          pst_pkg::ClsOther: oth_q <= pst_pkg::sat_inc(oth_q);
          default: ;
        endcase
      end else if (busy_q) begin
        if (a_done) wait_a_q <= 1'b0;
        if (p_done) wait_p_q <= 1'b0;
        if ((!wait_a_q || a_done) && (!wait_p_q || p_done)) begin
          busy_q <= 1'b0;
          out_vld_q <= 1'b1;
        end
      end
      if (out_vld_q && out_ready_i) out_vld_q <= 1'b0;
    end
  end

  logic ip_q, l4_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ip_q <= is_ip;
      l4_q <= is_l4;
    end
  end

  assign out_valid_o = out_vld_q;
  assign packet_class_o = cls_q;
  assign address_slot_o = ip_q ? a_res.slot : '0;
  assign address_total_o = ip_q ? a_res.total : '0;
  assign address_table_full_o = ip_q && a_res.full;
  assign port_slot_o = l4_q ? p_res.slot : '0;
  assign port_total_o = l4_q ? p_res.total : '0;
  assign port_table_full_o = l4_q && p_res.full;
  assign tcp_packets_o = tcp_q;
  assign udp_packets_o = udp_q;
  assign arp_packets_o = arp_q;
  assign other_packets_o = oth_q;
endmodule

### hdl/pst_checker.sv
// Port-level checker for the packet source tally block, with its bind.
module pst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  packet_class_o,
  input logic [31:0] tcp_packets_o,
  input logic [31:0] address_total_o,
  input logic        address_table_full_o
);
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input ready while result pending");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(packet_class_o))
    else $error("result changed while stalled");
  a_tcp_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && in_ready_o) |=> $stable(tcp_packets_o))
    else $error("tcp count moved without a beat");
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && address_table_full_o |-> address_total_o == 32'd0)
    else $error("full flag with nonzero total");
endmodule

bind packet_source_tally_top pst_checker u_pst_checker (.*);

### tb/sv/packet_source_tally_top_tb.sv
// Testbench for packet_source_tally_top: directed and randomized packet beats checked against a tally predictor.
`timescale 1ns / 100ps

module packet_source_tally_top_tb;
  localparam int unsigned NumRandom = 1750;
  localparam int unsigned IdleLimit = 5000;
  localparam logic [15:0] EthLldp = 16'd35020;

  typedef struct packed {
    logic [15:0] eth_type;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [15:0] source_port;
  } packet_t;

  typedef struct packed {
    pst_pkg::pkt_class_e cls;
    logic [7:0]  address_slot;
    logic [31:0] address_total;
    logic [7:0]  port_slot;
    logic [31:0] port_total;
    logic        address_full;
    logic        port_full;
    logic [31:0] tcp_cnt;
    logic [31:0] udp_cnt;
    logic [31:0] arp_cnt;
    logic [31:0] other_cnt;
  } tally_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] eth_type = '0;
  logic [7:0] ip_protocol = '0;
  logic [31:0] source_address = '0;
  logic [15:0] source_port = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] packet_class;
  logic [7:0] address_slot, port_slot;
  logic [31:0] address_total, port_total;
  logic address_table_full, port_table_full;
  logic [31:0] tcp_packets, udp_packets, arp_packets, other_packets;

  packet_t pending_q[$];
  tally_t tally_q[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  logic [31:0] addr_keys[pst_pkg::TableDepth];
  logic [31:0] addr_counts[pst_pkg::TableDepth];
  int unsigned addr_fill = 0;
  logic [15:0] port_keys[pst_pkg::TableDepth];
  logic [31:0] port_counts[pst_pkg::TableDepth];
  int unsigned port_fill = 0;
  logic [31:0] tcp_cnt = '0, udp_cnt = '0, arp_cnt = '0, other_cnt = '0;

  logic [31:0] addr_pool[$];
  logic [15:0] port_pool[$];

  always #10 clk_i = ~clk_i;

  packet_source_tally_top i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .eth_type_i          (eth_type),
    .ip_protocol_i       (ip_protocol),
    .source_address_i    (source_address),
    .source_port_i       (source_port),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .packet_class_o      (packet_class),
    .address_slot_o      (address_slot),
    .address_total_o     (address_total),
    .port_slot_o         (port_slot),
    .port_total_o        (port_total),
    .address_table_full_o(address_table_full),
    .port_table_full_o   (port_table_full),
    .tcp_packets_o       (tcp_packets),
    .udp_packets_o       (udp_packets),
    .arp_packets_o       (arp_packets),
    .other_packets_o     (other_packets)
  );

  function automatic logic [31:0] bump(logic [31:0] v);
    return (&v) ? v : v + 32'd1;
  endfunction

  function automatic void tally_address(input logic [31:0] key, inout tally_t t);
    for (int i = 0; i < addr_fill; i++) begin
      if (addr_keys[i] == key) begin
        addr_counts[i] = bump(addr_counts[i]);
        t.address_slot = i[7:0];
        t.address_total = addr_counts[i];
        return;
      end
    end
    if (addr_fill < pst_pkg::TableDepth) begin
      addr_keys[addr_fill] = key;
      addr_counts[addr_fill] = 32'd1;
      t.address_slot = addr_fill[7:0];
      t.address_total = 32'd1;
      addr_fill++;
    end else begin
      t.address_full = 1'b1;
    end
  endfunction

  function automatic void tally_port(input logic [15:0] key, inout tally_t t);
    for (int i = 0; i < port_fill; i++) begin
      if (port_keys[i] == key) begin
        port_counts[i] = bump(port_counts[i]);
        t.port_slot = i[7:0];
        t.port_total = port_counts[i];
        return;
      end
    end
    if (port_fill < pst_pkg::TableDepth) begin
      port_keys[port_fill] = key;
      port_counts[port_fill] = 32'd1;
      t.port_slot = port_fill[7:0];
      t.port_total = 32'd1;
      port_fill++;
    end else begin
      t.port_full = 1'b1;
    end
  endfunction

  function automatic tally_t predict_tally(packet_t p);
    tally_t t;
    t = '0;
    if (p.eth_type == pst_pkg::EthIpv4) begin
      if (p.ip_protocol == pst_pkg::ProtoTcp) begin
        t.cls = pst_pkg::ClsTcp;
        tcp_cnt = bump(tcp_cnt);
      end else if (p.ip_protocol == pst_pkg::ProtoUdp) begin
        t.cls = pst_pkg::ClsUdp;
        udp_cnt = bump(udp_cnt);
      end else begin
        t.cls = pst_pkg::ClsIpv4;
      end
      tally_address(p.source_address, t);
      if (t.cls != pst_pkg::ClsIpv4) tally_port(p.source_port, t);
    end else if (p.eth_type == pst_pkg::EthArp) begin
      t.cls = pst_pkg::ClsArp;
      arp_cnt = bump(arp_cnt);
    end else if (p.eth_type == pst_pkg::EthUncounted) begin
      t.cls = pst_pkg::ClsUncounted;
    end else begin
      t.cls = pst_pkg::ClsOther;
      other_cnt = bump(other_cnt);
    end
    t.tcp_cnt = tcp_cnt;
    t.udp_cnt = udp_cnt;
    t.arp_cnt = arp_cnt;
    t.other_cnt = other_cnt;
    return t;
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: %s got %0h expected %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  function automatic packet_t make_packet(logic [15:0] et, logic [7:0] pr, logic [31:0] sa,
                                          logic [15:0] sp);
    packet_t p;
    p.eth_type = et;
    p.ip_protocol = pr;
    p.source_address = sa;
    p.source_port = sp;
    return p;
  endfunction

  function automatic packet_t random_packet();
    packet_t p;
    int unsigned sel;
    p = make_packet(16'($urandom), 8'($urandom), $urandom, 16'($urandom));
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      p.eth_type = pst_pkg::EthIpv4;
      sel = $urandom_range(0, 9);
      if (sel < 4) p.ip_protocol = pst_pkg::ProtoTcp;
      else if (sel < 8) p.ip_protocol = pst_pkg::ProtoUdp;
      if (addr_pool.size() > 0 && $urandom_range(0, 1) == 0)
        p.source_address = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
      else
        addr_pool.push_back(p.source_address);
      if (port_pool.size() > 0 && $urandom_range(0, 1) == 0)
        p.source_port = port_pool[$urandom_range(0, port_pool.size() - 1)];
      else
        port_pool.push_back(p.source_port);
    end else if (sel < 82) begin
      p.eth_type = pst_pkg::EthArp;
    end else if (sel < 87) begin
      p.eth_type = pst_pkg::EthUncounted;
    end else if (sel < 90) begin
      p.eth_type = EthLldp;
    end
    return p;
  endfunction

  // driver: bursts with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin
    logic next_valid;
    packet_t p;
    next_valid = in_valid;
    if (!rst_ni) begin
      next_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        tally_q.push_back(predict_tally(make_packet(eth_type, ip_protocol,
                                                    source_address, source_port)));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          p = pending_q.pop_front();
          eth_type <= p.eth_type;
          ip_protocol <= p.ip_protocol;
          source_address <= p.source_address;
          source_port <= p.source_port;
          next_valid = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 400);
          end else begin
            burst_left--;
          end
        end
      end
    end
    in_valid <= next_valid;
  end

  // monitor: receiver stalls on a rotating mask
  logic [15:0] stall_mask = 16'hffff;
  always @(posedge clk_i) begin
    tally_t t;
    if (rst_ni && out_valid && out_ready) begin
      if (tally_q.size() == 0) begin
        report("unexpected beat", 32'd0, 32'd0);
      end else begin
        t = tally_q.pop_front();
        if (packet_class != t.cls)
          report("packet_class", 32'(packet_class), 32'(t.cls));
        if (address_slot != t.address_slot)
          report("address_slot", 32'(address_slot), 32'(t.address_slot));
        if (address_total != t.address_total)
          report("address_total", address_total, t.address_total);
        if (port_slot != t.port_slot)
          report("port_slot", 32'(port_slot), 32'(t.port_slot));
        if (port_total != t.port_total) report("port_total", port_total, t.port_total);
        if (address_table_full != t.address_full)
          report("address_table_full", 32'(address_table_full), 32'(t.address_full));
        if (port_table_full != t.port_full)
          report("port_table_full", 32'(port_table_full), 32'(t.port_full));
        if (tcp_packets != t.tcp_cnt) report("tcp_packets", tcp_packets, t.tcp_cnt);
        if (udp_packets != t.udp_cnt) report("udp_packets", udp_packets, t.udp_cnt);
        if (arp_packets != t.arp_cnt) report("arp_packets", arp_packets, t.arp_cnt);
        if (other_packets != t.other_cnt) report("other_packets", other_packets, t.other_cnt);
      end
    end
    if ($urandom_range(0, 63) == 0)
      stall_mask = ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
    stall_mask = {stall_mask[14:0], stall_mask[15]};
    out_ready <= rst_ni && stall_mask[0];
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_ni) idle_cycles <= '0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    pending_q.push_back(make_packet(pst_pkg::EthIpv4, pst_pkg::ProtoTcp, 32'h0, 16'h0));
    pending_q.push_back(make_packet(pst_pkg::EthIpv4, pst_pkg::ProtoTcp, 32'h0, 16'h0));
    pending_q.push_back(make_packet(pst_pkg::EthIpv4, pst_pkg::ProtoUdp, 32'hffffffff,
                                    16'hffff));
    pending_q.push_back(make_packet(pst_pkg::EthIpv4, pst_pkg::ProtoUdp, 32'hffffffff,
                                    16'h0));
    pending_q.push_back(make_packet(pst_pkg::EthIpv4, 8'h00, 32'h0, 16'hffff));
    pending_q.push_back(make_packet(pst_pkg::EthIpv4, 8'hff, 32'h12345678, 16'h1234));
    pending_q.push_back(make_packet(pst_pkg::EthIpv4, pst_pkg::ProtoTcp, 32'h12345678,
                                    16'h1234));
    pending_q.push_back(make_packet(pst_pkg::EthArp, 8'hff, 32'hffffffff, 16'hffff));
    pending_q.push_back(make_packet(pst_pkg::EthUncounted, pst_pkg::ProtoTcp, 32'h1, 16'h1));
    pending_q.push_back(make_packet(EthLldp, pst_pkg::ProtoUdp, 32'h2, 16'h2));
    pending_q.push_back(make_packet(16'h0000, 8'h00, 32'h0, 16'h0));
    pending_q.push_back(make_packet(16'hffff, 8'hff, 32'hffffffff, 16'hffff));
    pending_q.push_back(make_packet(16'h0801, pst_pkg::ProtoTcp, 32'h3, 16'h3));
    pending_q.push_back(make_packet(pst_pkg::EthIpv4, pst_pkg::ProtoUdp, 32'h0, 16'hffff));
    for (int i = 0; i < NumRandom; i++) pending_q.push_back(random_packet());
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    do begin
      @(negedge clk_i);
    end while (pending_q.size() != 0 || in_valid || tally_q.size() != 0);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

### packet_source_tally_top.f
hdl/pst_pkg.sv
hdl/pst_search.sv
hdl/packet_source_tally_top.sv
hdl/pst_checker.sv
tb/sv/packet_source_tally_top_tb.sv
